FILE: rtl/swcs_pkg.sv
// shared types, constants and tables of the swerve wheel command solver
package swcs_pkg;

  localparam int DefCordicSteps = 16;
  localparam int AtanIdxW = 5;

  localparam logic [29:0] InvGainQ30 = 30'd652032874;
  localparam logic signed [23:0] DriveMax = 24'sd8388607;
  localparam logic signed [15:0] SteerLim = 16'sd12868;

  // register indexes on the config port
  localparam logic [2:0] REG_X_SCALE       = 3'd0;
  localparam logic [2:0] REG_Y_SCALE       = 3'd1;
  localparam logic [2:0] REG_YAW_SCALE     = 3'd2;
  localparam logic [2:0] REG_HALF_WIDTH    = 3'd3;
  localparam logic [2:0] REG_HALF_LENGTH   = 3'd4;
  localparam logic [2:0] REG_DRIVE_GAIN    = 3'd5;
  localparam logic [2:0] REG_TIMEOUT_TICKS = 3'd6;

  typedef enum logic {
    JOB_VELOCITY = 1'b0,
    JOB_TIMEOUT  = 1'b1
  } job_kind_t;

  typedef struct packed {
    job_kind_t          kind;
    logic signed [15:0] lin_x;
    logic signed [15:0] lin_y;
    logic signed [15:0] yaw_rate;
  } job_t;

  typedef struct packed {
    logic [15:0] x_scale;
    logic [15:0] y_scale;
    logic [15:0] yaw_scale;
    logic [15:0] half_width;
    logic [15:0] half_length;
    logic [15:0] drive_gain;
    logic [15:0] timeout_ticks;
  } cfg_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_MLX, ST_MLY, ST_MYW, ST_MWT, ST_MHW, ST_MHL, ST_MCAP,
    ST_WSET, ST_CORD, ST_MAGL, ST_MAGH, ST_MAGS, ST_GAIN, ST_DRV, ST_OUT
  } back_state_t;

  // atan(2^-i) in Q.30
  function automatic logic [29:0] atan_q30(input logic [AtanIdxW-1:0] idx);
    logic [29:0] v;
    unique case (idx)
      5'd0:  v = 30'd843314857;
      5'd1:  v = 30'd497837829;
      5'd2:  v = 30'd263043837;
      5'd3:  v = 30'd133525159;
      5'd4:  v = 30'd67021687;
      5'd5:  v = 30'd33543516;
      5'd6:  v = 30'd16775851;
      5'd7:  v = 30'd8388437;
      5'd8:  v = 30'd4194283;
      5'd9:  v = 30'd2097149;
      5'd10: v = 30'd1048576;
      5'd11: v = 30'd524288;
      5'd12: v = 30'd262144;
      5'd13: v = 30'd131072;
      5'd14: v = 30'd65536;
      5'd15: v = 30'd32768;
      5'd16: v = 30'd16384;
      5'd17: v = 30'd8192;
      5'd18: v = 30'd4096;
      5'd19: v = 30'd2048;
      5'd20: v = 30'd1024;
      5'd21: v = 30'd512;
      5'd22: v = 30'd256;
      5'd23: v = 30'd128;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

FILE: rtl/swerve_wheel_command_solver_top.sv
// Swerve wheel command solver: a velocity command (s_tuser 0) yields one result with drive
// and steer for four wheels; a timer tick (s_tuser 1) yields a zero command with m_tuser set
// once the tick count passes timeout_ticks, otherwise nothing. A velocity command is solved
// by one shared multiplier and one cordic unit working the wheels in turn; a wheel with zero
// sideways speed skips its cordic iteration and magnitude states. Up to two jobs queue
// between the input side and the solver.
module swerve_wheel_command_solver_top import swcs_pkg::*; #(
  parameter int CORDIC_STEPS = DefCordicSteps
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [47:0]  s_tdata,   // lin_x, lin_y, yaw_rate
  input  logic         s_tuser,   // timer tick when set, else velocity command
  output logic         m_tvalid,
  input  logic         m_tready,
  // drive_front_left, drive_front_right, drive_rear_left, drive_rear_right,
  // steer_front_left, steer_front_right, steer_rear_left, steer_rear_right, zero pad
  output logic [159:0] m_tdata,
  output logic         m_tuser,   // from_timeout
  input  logic         cfg_we,
  input  logic [2:0]   cfg_addr,
  input  logic [15:0]  cfg_wdata
);

  cfg_t cfg;
  job_t in_item, push_job, pop_job;
  logic push, push_ready, pop_valid, pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.x_scale       <= 16'd4096;
      cfg.y_scale       <= 16'd4096;
      cfg.yaw_scale     <= 16'd4096;
      cfg.half_width    <= 16'd4784;
      cfg.half_length   <= 16'd6554;
      cfg.drive_gain    <= 16'd3318;
      cfg.timeout_ticks <= 16'd20;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_X_SCALE:       cfg.x_scale       <= cfg_wdata;
        REG_Y_SCALE:       cfg.y_scale       <= cfg_wdata;
        REG_YAW_SCALE:     cfg.yaw_scale     <= cfg_wdata;
        REG_HALF_WIDTH:    cfg.half_width    <= cfg_wdata;
        REG_HALF_LENGTH:   cfg.half_length   <= cfg_wdata;
        REG_DRIVE_GAIN:    cfg.drive_gain    <= cfg_wdata;
        REG_TIMEOUT_TICKS: cfg.timeout_ticks <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    in_item.kind     = job_kind_t'(s_tuser);
    in_item.lin_x    = s_tdata[15:0];
    in_item.lin_y    = s_tdata[31:16];
    in_item.yaw_rate = s_tdata[47:32];
  end

  swcs_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (s_tvalid),
    .in_ready      (s_tready),
    .in_item       (in_item),
    .timeout_ticks (cfg.timeout_ticks),
    .push          (push),
    .push_ready    (push_ready),
    .push_job      (push_job)
  );

  swcs_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_ready (push_ready),
    .push_job   (push_job),
    .pop_valid  (pop_valid),
    .pop        (pop),
    .pop_job    (pop_job)
  );

  swcs_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (pop_valid),
    .job_ready (pop),
    .job       (pop_job),
    .cfg       (cfg),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata),
    .out_flag  (m_tuser)
  );

`ifndef SYNTHESIS
  // a timeout result carries an all-zero command
  assert property (@(posedge clk) disable iff (rst) m_tvalid && m_tuser |-> m_tdata == '0)
    else $error("timeout result with nonzero wheel data");

  // only a tick can raise a timeout job
  assert property (@(posedge clk) disable iff (rst)
    push && push_job.kind == JOB_TIMEOUT |-> s_tvalid && s_tuser)
    else $error("timeout job without a tick");

  // the front never pushes into a full queue
  assert property (@(posedge clk) disable iff (rst) push |-> push_ready)
    else $error("job pushed into full queue");
`endif

endmodule

FILE: rtl/swcs_front.sv
// front end: accepts items, tracks command timeout, issues jobs
module swcs_front import swcs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  job_t        in_item,
  input  logic [15:0] timeout_ticks,
  output logic        push,
  input  logic        push_ready,
  output job_t        push_job
);

  logic [15:0] ticks;
  logic [15:0] ticks_next;
  logic        timed_out;
  logic        accept;
  logic        fire;

  assign in_ready = push_ready;
  assign accept   = in_valid && push_ready;

  assign ticks_next = (ticks != 16'hFFFF) ? ticks + 16'd1 : ticks;
  assign fire = !timed_out && (ticks_next > timeout_ticks);

  always_comb begin
    push_job = in_item;
    if (in_item.kind == JOB_VELOCITY) begin
      push = accept;
    end else begin
      push = accept && fire;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ticks     <= '0;
      timed_out <= 1'b1;
    end else if (accept) begin
      if (in_item.kind == JOB_VELOCITY) begin
        ticks     <= '0;
        timed_out <= 1'b0;
      end else begin
        ticks <= ticks_next;
        if (fire) timed_out <= 1'b1;
      end
    end
  end

endmodule

FILE: rtl/swcs_queue.sv
// two-entry job queue between front and back
module swcs_queue import swcs_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic push_ready,
  input  job_t push_job,
  output logic pop_valid,
  input  logic pop,
  output job_t pop_job
);

  job_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_job    = slots[rd_ptr];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= !wr_ptr;
      if (do_pop) rd_ptr <= !rd_ptr;
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: rtl/swcs_back.sv
// back end: shared multiplier and cordic solve four wheels, output register
module swcs_back import swcs_pkg::*; #(
  parameter int CORDIC_STEPS = DefCordicSteps
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         job_valid,
  output logic         job_ready,
  input  job_t         job,
  input  cfg_t         cfg,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [159:0] out_data,
  output logic         out_flag
);

  localparam int CntW = $clog2(CORDIC_STEPS);

  back_state_t state, state_next;

  job_t                  cur;
  logic signed [32:0]    linx, liny, yw;
  logic signed [49:0]    ohw, ohl;
  logic [1:0]            w;
  logic signed [35:0]    x, y;
  logic signed [31:0]    ang;
  logic                  fold;
  logic [CntW-1:0]       step;
  logic [47:0]           lo;
  logic [32:0]           mag;
  logic signed [65:0]    prod;
  logic signed [33:0]    mul_a;
  logic signed [31:0]    mul_b;
  logic signed [23:0]    drv [4];
  logic signed [14:0]    str [4];
  logic                  flag;

  // wheel vector forming
  logic signed [51:0] lx_w, ly_w, ohw_w, ohl_w, vx_w, vy_w;
  logic signed [33:0] vx, vy;
  logic               vx_neg;
  logic signed [35:0] fx, fy;
  always_comb begin
    lx_w  = 52'(signed'({linx, 14'b0}));
    ly_w  = 52'(signed'({liny, 14'b0}));
    ohw_w = 52'(ohw);
    ohl_w = 52'(ohl);
    vx_w  = w[0] ? lx_w + ohw_w : lx_w - ohw_w;
    vy_w  = w[1] ? ly_w - ohl_w : ly_w + ohl_w;
    vx    = vx_w[51:18];
    vy    = vy_w[51:18];
    vx_neg = vx[33];
    fx = vx_neg ? -36'(vx) : 36'(vx);
    fy = vx_neg ? -36'(vy) : 36'(vy);
  end

  // cordic iteration
  logic signed [35:0] xs, ys;
  logic signed [31:0] at;
  logic               y_pos;
  always_comb begin
    xs    = x >>> step;
    ys    = y >>> step;
    at    = 32'(atan_q30(AtanIdxW'(step)));
    y_pos = !y[35] && (y != '0);
  end

  // magnitude, drive and steer
  logic [66:0]        magsum;
  logic [33:0]        dmag;
  logic signed [23:0] d_sat, d_fold, d_out;
  logic signed [32:0] ang_r;
  logic signed [15:0] s_raw;
  logic signed [14:0] s_clip, s_out;
  always_comb begin
    magsum = {19'b0, lo} + {1'b0, prod[47:0], 18'b0};
    dmag   = prod[49:16];
    d_sat  = (dmag > 34'(DriveMax)) ? DriveMax : 24'(dmag);
    d_fold = fold ? -d_sat : d_sat;
    d_out  = w[1] ? -d_fold : d_fold;
    ang_r  = 33'(ang) + 33'sd65536;
    s_raw  = ang_r[32:17];
    if (s_raw > SteerLim) begin
      s_clip = 15'(SteerLim);
    end else if (s_raw < -SteerLim) begin
      s_clip = 15'(-SteerLim);
    end else begin
      s_clip = 15'(s_raw);
    end
    s_out = (w[0] ^ w[1]) ? -s_clip : s_clip;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (job_valid) state_next = (job.kind == JOB_TIMEOUT) ? ST_OUT : ST_MLX;
      end
      ST_MLX:  state_next = ST_MLY;
      ST_MLY:  state_next = ST_MYW;
      ST_MYW:  state_next = ST_MWT;
      ST_MWT:  state_next = ST_MHW;
      ST_MHW:  state_next = ST_MHL;
      ST_MHL:  state_next = ST_MCAP;
      ST_MCAP: state_next = ST_WSET;
      ST_WSET: state_next = (vy == '0) ? ST_GAIN : ST_CORD;
      ST_CORD: begin
        if (step == CntW'(CORDIC_STEPS - 1)) state_next = ST_MAGL;
      end
      ST_MAGL: state_next = ST_MAGH;
      ST_MAGH: state_next = ST_MAGS;
      ST_MAGS: state_next = ST_GAIN;
      ST_GAIN: state_next = ST_DRV;
      ST_DRV:  state_next = (w == 2'd3) ? ST_OUT : ST_WSET;
      ST_OUT: begin
        if (!out_valid || out_ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs of the sequencer: job handshake and multiplier operands
  always_comb begin
    job_ready = (state == ST_IDLE);
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      ST_MLX:  begin mul_a = 34'(cur.lin_x);    mul_b = 32'(cfg.x_scale);     end
      ST_MLY:  begin mul_a = 34'(cur.lin_y);    mul_b = 32'(cfg.y_scale);     end
      ST_MYW:  begin mul_a = 34'(cur.yaw_rate); mul_b = 32'(cfg.yaw_scale);   end
      ST_MHW:  begin mul_a = 34'(yw);           mul_b = 32'(cfg.half_width);  end
      ST_MHL:  begin mul_a = 34'(yw);           mul_b = 32'(cfg.half_length); end
      ST_MAGL: begin mul_a = 34'({1'b0, x[17:0]});  mul_b = 32'(InvGainQ30);  end
      ST_MAGH: begin mul_a = 34'({1'b0, x[35:18]}); mul_b = 32'(InvGainQ30);  end
      ST_GAIN: begin mul_a = 34'(mag);          mul_b = 32'(cfg.drive_gain);  end
      default: begin mul_a = '0;                mul_b = '0;                   end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_OUT && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    unique case (state)
      ST_IDLE: begin
        cur <= job;
        w   <= '0;
        if (job_valid && job.kind == JOB_TIMEOUT) begin
          flag <= 1'b1;
          for (int i = 0; i < 4; i++) begin
            drv[i] <= '0;
            str[i] <= '0;
          end
        end else begin
          flag <= 1'b0;
        end
      end
      ST_MLY:  linx <= prod[32:0];
      ST_MYW:  liny <= prod[32:0];
      ST_MWT:  yw   <= prod[32:0];
      ST_MHL:  ohw  <= prod[49:0];
      ST_MCAP: ohl  <= prod[49:0];
      ST_WSET: begin
        fold <= vx_neg;
        x    <= fx;
        y    <= fy;
        ang  <= '0;
        step <= '0;
        mag  <= fx[32:0];
      end
      ST_CORD: begin
        if (y_pos) begin
          x   <= x + ys;
          y   <= y - xs;
          ang <= ang + at;
        end else begin
          x   <= x - ys;
          y   <= y + xs;
          ang <= ang - at;
        end
        step <= step + CntW'(1);
      end
      ST_MAGH: lo  <= prod[47:0];
      ST_MAGS: mag <= magsum[62:30];
      ST_DRV: begin
        drv[w] <= d_out;
        str[w] <= s_out;
        w      <= w + 2'd1;
      end
      ST_OUT: begin
        if (!out_valid || out_ready) begin
          out_flag <= flag;
          out_data <= {4'b0, str[3], str[2], str[1], str[0],
                       drv[3], drv[2], drv[1], drv[0]};
        end
      end
      default: begin
      end
    endcase
  end

endmodule
